/* rtl/btli_pkg.sv */
`timescale 1ns / 1ps
// Package for the breakpoint table interpolation unit.
// Holds table sizing constants, operation and status codes, and the sequencer states.
package btli_pkg;

	// Table sizing.
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths of one table entry.
	localparam int TICK_W  = 32;
	localparam int VAL_W   = 16;
	localparam int ENTRY_W = TICK_W + VAL_W;

	// Operation codes.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_BAD_INDEX = 2'd2;

	// Reset value of the empty-table result, 0.5 in Q1.15.
	localparam logic [VAL_W-1:0] EMPTY_RESET = 16'd16384;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_QRD0,
		S_QCK0,
		S_QCKL,
		S_SRD,
		S_SCMP,
		S_QRDA,
		S_QRDB,
		S_QCKB,
		S_MUL,
		S_DIV,
		S_SHIFT,
		S_WNEW,
		S_OUT
	} state_t;

endpackage

/* rtl/btli_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Used for the breakpoint storage; depends on nothing else.
module btli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/breakpoint_table_linear_interp_unit.sv */
`timescale 1ns / 1ps
// Top level of the breakpoint table with linear interpolation.
// Depends on btli_pkg and on the btli_ram storage.
//
// Channel | Signals                                      | Direction
// cfg     | cfg_valid, cfg_ready, cfg_data               | in
// in      | in_valid, in_ready, operation, tick,         | in
//         | point_value, index                           |
// out     | out_valid, out_ready, result_value,          | out
//         | point_count, status                          |
//
// One request is worked on at a time; in_ready is high only while the sequencer is idle.
// Insert runs a binary search and then shifts entries up; remove shifts entries down from the index;
// query runs a binary search plus a 16-step serial divider.
// The table memory has one write and one read port, and the divider is bit-serial.
// Reset clears the point count and restores the empty value; the table needs no clearing.
// A result waiting in the output register holds the sequencer until it is taken.
module breakpoint_table_linear_interp_unit
	import btli_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic signed [31:0] tick,
	input  logic [15:0] point_value,
	input  logic [5:0]  index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] result_value,
	output logic [6:0]  point_count,
	output logic [1:0]  status
);

	state_t state_q, state_d;

	logic [VAL_W-1:0]         empty_q;
	logic [1:0]               op_q;
	logic signed [TICK_W-1:0] tick_q;
	logic [VAL_W-1:0]         val_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         lo_q, hi_q;
	logic [CNT_W-1:0]         mid_q;
	logic [CNT_W-1:0]         sh_q;
	logic                     pend_q;
	logic [ADDR_W-1:0]        pend_addr_q;
	logic signed [TICK_W-1:0] t0_q;
	logic [VAL_W-1:0]         v0_q;
	logic [VAL_W-1:0]         mag_q;
	logic                     up_q;
	logic [31:0]              span_q, dt_q;
	logic [31:0]              rem_q;
	logic [15:0]              pb_q, q_q;
	logic [3:0]               dcnt_q;
	logic [VAL_W-1:0]         res_q;
	logic [1:0]               sts_q;
	logic                     out_valid_q;
	logic [15:0]              out_res_q;
	logic [6:0]               out_cnt_q;
	logic [1:0]               out_sts_q;

	// Memory port signals.
	logic               mem_we, mem_re;
	logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
	logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
	logic signed [TICK_W-1:0] rd_tick;
	logic [VAL_W-1:0]   rd_val;

	// Search and shift helpers.
	logic [CNT_W-1:0] mid;
	logic [CNT_W-1:0] lo_m1;
	logic             sh_active;
	logic [CNT_W-1:0] sh_src;
	logic [CNT_W-1:0] cnt_m1;

	// Interpolation helpers.
	logic signed [TICK_W:0] span_w, dt_w;
	logic [47:0]            prod;
	logic [32:0]            rem_try;
	logic                   qbit;
	logic [15:0]            q_next;

	btli_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign rd_tick = signed'(mem_rdata[ENTRY_W-1:VAL_W]);
	assign rd_val  = mem_rdata[VAL_W-1:0];

	assign cfg_ready    = 1'b1;
	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign result_value = out_res_q;
	assign point_count  = out_cnt_q;
	assign status       = out_sts_q;

	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign lo_m1  = lo_q - CNT_W'(1);
	assign cnt_m1 = cnt_q - CNT_W'(1);

	// Insert moves entries up from the top; remove moves them down from the index.
	always_comb begin
		if (op_q == OP_INSERT) begin
			sh_active = (sh_q > lo_q);
			sh_src    = sh_q - CNT_W'(1);
		end else begin
			sh_active = ((sh_q + CNT_W'(1)) < cnt_q);
			sh_src    = sh_q + CNT_W'(1);
		end
	end

	// Interpolation arithmetic.
	assign span_w  = (TICK_W+1)'(rd_tick) - (TICK_W+1)'(t0_q);
	assign dt_w    = (TICK_W+1)'(tick_q) - (TICK_W+1)'(t0_q);
	assign prod    = 48'(mag_q) * 48'(dt_q);
	assign rem_try = {rem_q, pb_q[15]};
	assign qbit    = (rem_try >= {1'b0, span_q});
	assign q_next  = {q_q[14:0], qbit};

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (operation)
						OP_INSERT: state_d = (32'(cnt_q) >= CAPACITY) ? S_OUT : S_SRD;
						OP_REMOVE: state_d = (32'(index) >= 32'(cnt_q)) ? S_OUT : S_SHIFT;
						OP_QUERY:  state_d = (cnt_q == '0) ? S_OUT : S_QRD0;
						default:   state_d = S_OUT;
					endcase
				end
			end
			S_QRD0: state_d = S_QCK0;
			S_QCK0: state_d = (tick_q <= rd_tick) ? S_OUT : S_QCKL;
			S_QCKL: state_d = (tick_q >= rd_tick) ? S_OUT : S_SRD;
			S_SRD: begin
				if (lo_q < hi_q) begin
					state_d = S_SCMP;
				end else if (op_q == OP_INSERT) begin
					state_d = S_SHIFT;
				end else begin
					state_d = S_QRDA;
				end
			end
			S_SCMP: state_d = S_SRD;
			S_QRDA: state_d = S_QRDB;
			S_QRDB: state_d = S_QCKB;
			S_QCKB: state_d = S_MUL;
			S_MUL:  state_d = S_DIV;
			S_DIV:  state_d = (dcnt_q == 4'd15) ? S_OUT : S_DIV;
			S_SHIFT: begin
				if (!sh_active && !pend_q) begin
					state_d = (op_q == OP_INSERT) ? S_WNEW : S_OUT;
				end
			end
			S_WNEW: state_d = S_OUT;
			S_OUT:  state_d = (!out_valid_q || out_ready) ? S_IDLE : S_OUT;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = pend_addr_q;
		mem_wdata = mem_rdata;
		case (state_q)
			S_QRD0: begin
				mem_re = 1'b1;
			end
			S_QCK0: begin
				mem_re    = 1'b1;
				mem_raddr = cnt_m1[ADDR_W-1:0];
			end
			S_SRD: begin
				mem_re    = (lo_q < hi_q);
				mem_raddr = mid[ADDR_W-1:0];
			end
			S_QRDA: begin
				mem_re    = 1'b1;
				mem_raddr = lo_m1[ADDR_W-1:0];
			end
			S_QRDB: begin
				mem_re    = 1'b1;
				mem_raddr = lo_q[ADDR_W-1:0];
			end
			S_SHIFT: begin
				mem_re    = sh_active;
				mem_raddr = sh_src[ADDR_W-1:0];
				mem_we    = pend_q;
			end
			S_WNEW: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q[ADDR_W-1:0];
				mem_wdata = {tick_q, val_q};
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// State and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			empty_q     <= EMPTY_RESET;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				empty_q <= cfg_data;
			end
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_SHIFT: begin
					pend_q <= sh_active;
					if (!sh_active && !pend_q && op_q == OP_REMOVE) begin
						cnt_q <= cnt_m1;
					end
				end
				S_WNEW: cnt_q <= cnt_q + CNT_W'(1);
				default: pend_q <= 1'b0;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q   <= operation;
				tick_q <= tick;
				val_q  <= point_value;
				lo_q   <= '0;
				hi_q   <= cnt_q;
				sh_q   <= (operation == OP_REMOVE) ? CNT_W'(index) : cnt_q;
				res_q  <= '0;
				sts_q  <= ST_OK;
				if (operation == OP_INSERT && 32'(cnt_q) >= CAPACITY) begin
					sts_q <= ST_FULL;
				end
				if (operation == OP_REMOVE && 32'(index) >= 32'(cnt_q)) begin
					sts_q <= ST_BAD_INDEX;
				end
				if (operation == OP_QUERY && cnt_q == '0) begin
					res_q <= empty_q;
				end
			end
			S_QCK0: res_q <= rd_val;
			S_QCKL: res_q <= rd_val;
			S_SRD: begin
				mid_q <= mid;
			end
			S_SCMP: begin
				if (tick_q < rd_tick) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q + CNT_W'(1);
				end
			end
			S_QRDB: begin
				t0_q <= rd_tick;
				v0_q <= rd_val;
			end
			S_QCKB: begin
				span_q <= span_w[31:0];
				dt_q   <= dt_w[31:0];
				up_q   <= (rd_val >= v0_q);
				mag_q  <= (rd_val >= v0_q) ? (rd_val - v0_q) : (v0_q - rd_val);
			end
			S_MUL: begin
				rem_q  <= prod[47:16];
				pb_q   <= prod[15:0];
				q_q    <= '0;
				dcnt_q <= '0;
			end
			S_DIV: begin
				rem_q  <= qbit ? 32'(rem_try - {1'b0, span_q}) : rem_try[31:0];
				pb_q   <= {pb_q[14:0], 1'b0};
				q_q    <= q_next;
				dcnt_q <= dcnt_q + 4'd1;
				if (dcnt_q == 4'd15) begin
					res_q <= up_q ? (v0_q + q_next) : (v0_q - q_next);
				end
			end
			S_SHIFT: begin
				pend_addr_q <= sh_q[ADDR_W-1:0];
				if (sh_active) begin
					sh_q <= sh_src;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_res_q <= res_q;
					out_cnt_q <= 7'(cnt_q);
					out_sts_q <= sts_q;
				end
			end
			default: begin
				hi_q <= hi_q;
			end
		endcase
	end

endmodule
